FILE: hdl/lacp_pkg.sv
// Package for the layered box collision probe: sizes, stream field offsets,
// shared types and the microcode table of the probe sequencer.
// Depends on nothing; every module of the block imports it.
package lacp_pkg;

    // Table and coordinate sizes
    localparam int MAX_BOXES  = 16;
    localparam int COORD_BITS = 16;
    localparam int IDX_W      = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int SIZE_W     = 15;
    localparam int EDGE_W     = ((COORD_BITS > SIZE_W) ? COORD_BITS : SIZE_W) + 2;
    localparam int LAYER_W    = 4;
    localparam int SLOT_W     = 4;
    localparam int FIELD_C_W  = 16;

    // Layer code that means no layer
    localparam logic [LAYER_W-1:0] LAYER_NONE = '0;

    // Input tdata layout, lowest bit first
    localparam int IN_SLOT_LO = 0;
    localparam int IN_EN_LO   = IN_SLOT_LO + SLOT_W;
    localparam int IN_OWN_LO  = IN_EN_LO + 1;
    localparam int IN_TGT_LO  = IN_OWN_LO + LAYER_W;
    localparam int IN_CX_LO   = IN_TGT_LO + LAYER_W;
    localparam int IN_CY_LO   = IN_CX_LO + FIELD_C_W;
    localparam int IN_W_LO    = IN_CY_LO + FIELD_C_W;
    localparam int IN_H_LO    = IN_W_LO + SIZE_W;
    localparam int IN_BITS    = IN_H_LO + SIZE_W;
    localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W = 8;

    // Command codes carried in the input tuser
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_PROBE = 1'b1;

    // Geometry of one box as stored in the RAM
    typedef struct packed {
        logic signed [COORD_BITS-1:0] cx;
        logic signed [COORD_BITS-1:0] cy;
        logic [SIZE_W-1:0]            w;
        logic [SIZE_W-1:0]            h;
    } t_geom;

    // Geometry RAM access
    typedef struct packed {
        logic             we;
        logic             re;
        logic [IDX_W-1:0] addr;
        t_geom            wdata;
    } t_ram_req;

    // Read address source of a microcode step
    typedef enum logic [1:0] {
        RD_SLOT,
        RD_ZERO,
        RD_IDX
    } t_rd_sel;

    // Jump condition of a microcode step
    typedef enum logic [2:0] {
        C_NONE,
        C_PROBE,
        C_SRC_BAD,
        C_WALK_END,
        C_OUT_FREE
    } t_cond;

    // Microcode step addresses
    typedef logic [1:0] t_step;
    localparam t_step STEP_IDLE = 2'd0;
    localparam t_step STEP_SRC  = 2'd1;
    localparam t_step STEP_WALK = 2'd2;
    localparam t_step STEP_DONE = 2'd3;

    // One control word
    typedef struct packed {
        logic    accept;
        logic    load_src;
        logic    eval;
        logic    finish;
        t_rd_sel rd_sel;
        t_cond   cond;
        t_step   target;
    } t_ctl;

    // Status from the datapath back to the sequencer
    typedef struct packed {
        logic probe_acc;
        logic src_bad;
        logic walk_end;
        logic final_done;
    } t_status;

    // Control store
    function automatic t_ctl rom_word(input t_step step);
        t_ctl w;
        w = '{accept: 1'b0, load_src: 1'b0, eval: 1'b0, finish: 1'b0,
              rd_sel: RD_SLOT, cond: C_NONE, target: STEP_IDLE};
        case (step)
            STEP_IDLE: begin
                w.accept = 1'b1;
                w.rd_sel = RD_SLOT;
                w.cond   = C_PROBE;
                w.target = STEP_SRC;
            end
            STEP_SRC: begin
                w.load_src = 1'b1;
                w.rd_sel   = RD_ZERO;
                w.cond     = C_SRC_BAD;
                w.target   = STEP_DONE;
            end
            STEP_WALK: begin
                w.eval   = 1'b1;
                w.rd_sel = RD_IDX;
                w.cond   = C_WALK_END;
                w.target = STEP_DONE;
            end
            STEP_DONE: begin
                w.finish = 1'b1;
                w.cond   = C_OUT_FREE;
                w.target = STEP_IDLE;
            end
            default: begin
                w.cond   = C_NONE;
                w.target = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

FILE: hdl/layered_aabb_collision_probe_top.sv
// Channel   Dir  Handshake              Payload
// s (cmd)   in   i_s_tvalid/o_s_tready  tdata: box write or probe fields, tuser: cmd
// m (res)   out  o_m_tvalid/i_m_tready  tdata: source/hit slot, tuser: hit, tlast: last
//
// A write is stored as it is accepted. A probe runs slot read, source load, a walk
// of one table entry per cycle through the single read port of the geometry RAM
// while the output is not blocked, and the final result; a blocked output adds its wait.
// A probe of a disabled source or one that targets no layer skips the walk.
// Synchronous active-low reset clears the box flags at once (all boxes disabled)
// and the sequencer; geometry holds no reset and needs no clearing pass.
// New commands are taken only between probes; results wait in the output register.
module layered_aabb_collision_probe_top
    import lacp_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // slot[3:0], enable[4], own_layer[8:5], target_layer[12:9], centre_x[28:13],
    // centre_y[44:29], width[59:45], height[74:60], zero pad[79:75]
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    // cmd
    input  logic                   i_s_tuser,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // source_slot[3:0], hit_slot[7:4]
    output logic [OUT_TDATA_W-1:0] o_m_tdata,
    // hit
    output logic                   o_m_tuser,
    output logic                   o_m_tlast
);

    t_ctl     ctl;
    t_status  status;
    t_ram_req ram_req;
    t_geom    ram_rdata;

    lacp_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_ctl    (ctl)
    );

    lacp_geom_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (ram_rdata)
    );

    lacp_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .o_status    (status),
        .i_s_tvalid  (i_s_tvalid),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_s_tready  (o_s_tready),
        .o_ram_req   (ram_req),
        .i_ram_rdata (ram_rdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

endmodule

FILE: hdl/lacp_geom_ram.sv
// Box geometry store: one port, written or read per cycle, registered read.
// Depends on lacp_pkg for the table depth and the geometry type.
module lacp_geom_ram
    import lacp_pkg::*;
(
    input  logic     i_clk,
    input  t_ram_req i_req,
    output t_geom    o_rdata
);

    t_geom r_mem [MAX_BOXES];
    t_geom r_rdata;

    // Write or read one entry
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/lacp_seq.sv
// Probe sequencer: step counter over the microcode table with conditional jumps.
// Depends on lacp_pkg for the control store and the control/status types.
module lacp_seq
    import lacp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_status i_status,
    output t_ctl    o_ctl
);

    t_step r_step;
    t_step n_step;
    t_ctl  ctl;

    // Fetch the control word of the current step
    always_comb begin
        ctl   = rom_word(r_step);
        o_ctl = ctl;
    end

    // Pick the next step
    always_comb begin
        case (ctl.cond)
            C_NONE:     n_step = ctl.target;
            C_PROBE:    n_step = i_status.probe_acc  ? ctl.target : r_step;
            C_SRC_BAD:  n_step = i_status.src_bad    ? ctl.target : r_step + 2'd1;
            C_WALK_END: n_step = i_status.walk_end   ? ctl.target : r_step;
            C_OUT_FREE: n_step = i_status.final_done ? ctl.target : r_step;
            default:    n_step = STEP_IDLE;
        endcase
    end

    // Advance the step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

FILE: hdl/lacp_datapath.sv
// Probe datapath: box flag table, source edges, overlap test, pending hit and
// output register. Depends on lacp_pkg; drives the geometry RAM port.
module lacp_datapath
    import lacp_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_ctl                   i_ctl,
    output t_status                o_status,
    input  logic                   i_s_tvalid,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    input  logic                   i_s_tuser,
    output logic                   o_s_tready,
    output t_ram_req               o_ram_req,
    input  t_geom                  i_ram_rdata,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata,
    output logic                   o_m_tuser,
    output logic                   o_m_tlast
);

    // Sign-extend or trim a coordinate field to the internal width
    function automatic logic signed [COORD_BITS-1:0] to_coord(input logic [FIELD_C_W-1:0] f);
        logic signed [31:0] v;
        v = 32'(signed'(f));
        return COORD_BITS'(v);
    endfunction

    function automatic logic signed [EDGE_W-1:0] edge_lo(
        input logic signed [COORD_BITS-1:0] c, input logic [SIZE_W-1:0] s);
        logic signed [EDGE_W-1:0] ce;
        logic signed [EDGE_W-1:0] he;
        ce = EDGE_W'(c);
        he = EDGE_W'(s[SIZE_W-1:1]);
        return ce - he;
    endfunction

    function automatic logic signed [EDGE_W-1:0] edge_hi(
        input logic signed [COORD_BITS-1:0] c, input logic [SIZE_W-1:0] s);
        logic signed [EDGE_W-1:0] ce;
        logic signed [EDGE_W-1:0] he;
        ce = EDGE_W'(c);
        he = EDGE_W'(s[SIZE_W-1:1]);
        return ce + he;
    endfunction

    // Input fields
    logic [SLOT_W-1:0]  in_slot;
    logic               in_en;
    logic [LAYER_W-1:0] in_own;
    logic [LAYER_W-1:0] in_tgt;
    logic               slot_ok;
    logic               in_acc;
    logic               probe_acc;

    assign in_slot = i_s_tdata[IN_SLOT_LO +: SLOT_W];
    assign in_en   = i_s_tdata[IN_EN_LO];
    assign in_own  = i_s_tdata[IN_OWN_LO +: LAYER_W];
    assign in_tgt  = i_s_tdata[IN_TGT_LO +: LAYER_W];
    assign slot_ok = (32'(in_slot) < MAX_BOXES);
    assign in_acc  = i_ctl.accept && i_s_tvalid;
    assign probe_acc = in_acc && (i_s_tuser == CMD_PROBE);
    assign o_s_tready = i_ctl.accept;

    // Flag table, cleared by reset
    logic               r_flag_en  [MAX_BOXES];
    logic [LAYER_W-1:0] r_flag_own [MAX_BOXES];
    logic [LAYER_W-1:0] r_flag_tgt [MAX_BOXES];

    // Read side registers, aligned with the RAM read data
    logic               r_rd_en;
    logic [LAYER_W-1:0] r_rd_own;
    logic [LAYER_W-1:0] r_rd_tgt;
    logic [IDX_W-1:0]   r_rd_idx;
    logic [IDX_W-1:0]   r_idx;

    // Source box
    logic [SLOT_W-1:0]        r_src_slot;
    logic                     r_src_ok_slot;
    logic [LAYER_W-1:0]       r_src_tgt;
    logic signed [EDGE_W-1:0] r_src_l;
    logic signed [EDGE_W-1:0] r_src_r;
    logic signed [EDGE_W-1:0] r_src_t;
    logic signed [EDGE_W-1:0] r_src_b;

    // Pending hit and output register
    logic             r_pend_valid;
    logic [IDX_W-1:0] r_pend_slot;
    logic             r_out_valid;
    logic [SLOT_W-1:0] r_out_src;
    logic [SLOT_W-1:0] r_out_hslot;
    logic             r_out_hit;
    logic             r_out_last;

    // Candidate test
    logic signed [EDGE_W-1:0] cand_l;
    logic signed [EDGE_W-1:0] cand_r;
    logic signed [EDGE_W-1:0] cand_t;
    logic signed [EDGE_W-1:0] cand_b;
    logic     cand_hit;
    logic     need_push;
    logic     out_free;
    logic     stall;
    logic     walk_go;
    t_ram_req req;

    always_comb begin
        cand_l = edge_lo(i_ram_rdata.cx, i_ram_rdata.w);
        cand_r = edge_hi(i_ram_rdata.cx, i_ram_rdata.w);
        cand_t = edge_lo(i_ram_rdata.cy, i_ram_rdata.h);
        cand_b = edge_hi(i_ram_rdata.cy, i_ram_rdata.h);
        cand_hit = (r_rd_idx != IDX_W'(r_src_slot)) && r_rd_en && (r_rd_own == r_src_tgt)
                   && (r_src_r >= cand_l) && (r_src_l <= cand_r)
                   && (r_src_b >= cand_t) && (r_src_t <= cand_b);
        out_free  = !r_out_valid || i_m_tready;
        need_push = cand_hit && r_pend_valid;
        stall     = i_ctl.eval && need_push && !out_free;
        walk_go   = i_ctl.eval && !stall;
    end

    // Drive the geometry RAM port
    always_comb begin
        req.wdata.cx = to_coord(i_s_tdata[IN_CX_LO +: FIELD_C_W]);
        req.wdata.cy = to_coord(i_s_tdata[IN_CY_LO +: FIELD_C_W]);
        req.wdata.w  = i_s_tdata[IN_W_LO +: SIZE_W];
        req.wdata.h  = i_s_tdata[IN_H_LO +: SIZE_W];
        req.we = in_acc && (i_s_tuser == CMD_WRITE) && slot_ok;
        req.re = probe_acc || i_ctl.load_src || walk_go;
        case (i_ctl.rd_sel)
            RD_SLOT: req.addr = IDX_W'(in_slot);
            RD_ZERO: req.addr = '0;
            RD_IDX:  req.addr = r_idx;
            default: req.addr = '0;
        endcase
        o_ram_req = req;
    end

    // Status for the sequencer
    always_comb begin
        o_status.probe_acc  = probe_acc;
        o_status.src_bad    = !(r_src_ok_slot && r_rd_en && (r_rd_tgt != LAYER_NONE));
        o_status.walk_end   = walk_go && (r_rd_idx == IDX_W'(MAX_BOXES - 1));
        o_status.final_done = i_ctl.finish && out_free;
    end

    // Update the flag table on writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_BOXES; i++) begin
                r_flag_en[i]  <= 1'b0;
                r_flag_own[i] <= '0;
                r_flag_tgt[i] <= '0;
            end
        end else if (req.we) begin
            r_flag_en[req.addr]  <= in_en;
            r_flag_own[req.addr] <= in_own;
            r_flag_tgt[req.addr] <= in_tgt;
        end
    end

    // Read flags alongside the RAM and advance the walk index
    always_ff @(posedge i_clk) begin
        if (req.re) begin
            r_rd_en  <= r_flag_en[req.addr];
            r_rd_own <= r_flag_own[req.addr];
            r_rd_tgt <= r_flag_tgt[req.addr];
            r_rd_idx <= req.addr;
        end
        if (i_ctl.load_src) begin
            r_idx <= IDX_W'(1);
        end else if (walk_go) begin
            r_idx <= r_idx + IDX_W'(1);
        end
    end

    // Capture the source slot, then its flags and edges
    always_ff @(posedge i_clk) begin
        if (probe_acc) begin
            r_src_slot    <= in_slot;
            r_src_ok_slot <= slot_ok;
        end
        if (i_ctl.load_src) begin
            r_src_tgt <= r_rd_tgt;
            r_src_l   <= cand_l;
            r_src_r   <= cand_r;
            r_src_t   <= cand_t;
            r_src_b   <= cand_b;
        end
    end

    // Hold one hit back until the next hit or the end shows whether it is last
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_ctl.load_src) begin
                r_pend_valid <= 1'b0;
            end else if (walk_go && cand_hit) begin
                r_pend_valid <= 1'b1;
            end else if (o_status.final_done) begin
                r_pend_valid <= 1'b0;
            end
            if ((walk_go && need_push) || o_status.final_done) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Load the output transaction
    always_ff @(posedge i_clk) begin
        if (walk_go && cand_hit) begin
            r_pend_slot <= r_rd_idx;
        end
        if (walk_go && need_push) begin
            r_out_src   <= r_src_slot;
            r_out_hslot <= SLOT_W'(r_pend_slot);
            r_out_hit   <= 1'b1;
            r_out_last  <= 1'b0;
        end else if (o_status.final_done) begin
            r_out_src   <= r_src_slot;
            r_out_hslot <= r_pend_valid ? SLOT_W'(r_pend_slot) : '0;
            r_out_hit   <= r_pend_valid;
            r_out_last  <= 1'b1;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_hslot, r_out_src};
    assign o_m_tuser  = r_out_hit;
    assign o_m_tlast  = r_out_last;

    // Checks
    a_no_rw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(req.we && req.re))
        else $error("geometry RAM written and read in one cycle");

    a_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_status.final_done |=> (r_out_valid && r_out_last && !r_pend_valid))
        else $error("probe end did not leave a last transaction");

    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_hit) |-> r_out_last)
        else $error("empty result not marked last");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stall |=> ($stable(r_rd_idx) && $stable(r_idx) && r_pend_valid))
        else $error("walk moved while the output was blocked");

endmodule
